### rtl/radix_page_table_walker_core_assert.svh
// Assertion macros used by the checker of the page table walker.
// Depends on nothing; include it by its bare file name.
`ifndef RADIX_PAGE_TABLE_WALKER_CORE_ASSERT_SVH
`define RADIX_PAGE_TABLE_WALKER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPTW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("radix_page_table_walker_core: assertion violated");

// The consequent must hold in the cycle after the antecedent.
`define RPTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("radix_page_table_walker_core: assertion violated");

`endif

### rtl/rptw_pkg.sv
// Shared types, sizes and codes of the radix page table walker.
// Depends on nothing; rptw_ctrl, rptw_datapath, the top level and the checker import it.
package rptw_pkg;

	localparam int NUM_FRAMES = 64;
	localparam int LEVELS = 5;
	localparam int INDEX_BITS = 9;

	localparam int ENTRIES = 1 << INDEX_BITS;
	localparam int DEPTH = NUM_FRAMES * ENTRIES;
	localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int ADDR_W = FRAME_W + INDEX_BITS;

	localparam int VPN_W = 45;
	localparam int PPN_W = 52;
	// An entry keeps its valid bit and the 52-bit page or frame number above it.
	localparam int ENT_W = PPN_W + 1;

	localparam int ROOT_W = 6;
	localparam int FFREE_W = 7;
	localparam int FU_W = $clog2(NUM_FRAMES + 1);
	localparam int NXT_W = ((FU_W > FFREE_W) ? FU_W : FFREE_W) + 1;
	localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = FFREE_W;
	localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'd1;

	typedef struct packed {
		logic             mode;
		logic [VPN_W-1:0] vpn;
		logic [PPN_W-1:0] ppn;
		logic             unmap;
	} req_t;

	typedef struct packed {
		logic             mapped;
		logic [PPN_W-1:0] ppn_out;
		logic             status;
	} rsp_t;

	typedef struct packed {
		logic take;
		logic rd;
		logic adv;
		logic clr;
		logic zero;
		logic link;
		logic leaf;
		logic hit;
		logic abort;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic unmap;
		logic last_lvl;
		logic root_bad;
		logic ent_valid;
		logic ent_follow;
		logic alloc_bad;
		logic clr_last;
		logic zero_last;
		logic out_busy;
	} sts_t;

endpackage

### rtl/rptw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module rptw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/rptw_ctrl.sv
// Walk sequencer of the page table walker: reset clear, level walk, allocation.
// Depends on rptw_pkg; drives the datapath through cmd_t and reads sts_t.
module rptw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rptw_pkg::sts_t sts,
	output rptw_pkg::cmd_t cmd
);
	import rptw_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_ZERO,
		ST_LINK,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d = sts.root_bad ? ST_FINISH : ST_READ;
				end
			end
			ST_READ: begin
				// An update writes the leaf without reading it first.
				if (!sts.mode && sts.last_lvl) begin
					cmd.leaf = 1'b1;
					state_d = ST_FINISH;
				end else begin
					cmd.rd = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.last_lvl) begin
					cmd.hit = sts.ent_valid;
					state_d = ST_FINISH;
				end else if (sts.ent_follow) begin
					cmd.adv = 1'b1;
					state_d = ST_READ;
				end else if (sts.mode || sts.unmap) begin
					state_d = ST_FINISH;
				end else if (sts.alloc_bad) begin
					cmd.abort = 1'b1;
					state_d = ST_FINISH;
				end else begin
					state_d = ST_ZERO;
				end
			end
			ST_ZERO: begin
				cmd.zero = 1'b1;
				if (sts.zero_last) begin
					state_d = ST_LINK;
				end
			end
			ST_LINK: begin
				cmd.link = 1'b1;
				state_d = ST_READ;
			end
			ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/rptw_datapath.sv
// Datapath of the page table walker: registers, frame allocator, result register
// and the frame memory. Depends on rptw_pkg and rptw_ram; obeys cmd_t from rptw_ctrl.
module rptw_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rptw_pkg::req_t                 req,
	output rptw_pkg::rsp_t                 rsp,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	input  logic                           cfg_valid,
	input  logic [rptw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rptw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  rptw_pkg::cmd_t                 cmd,
	output rptw_pkg::sts_t                 sts
);
	import rptw_pkg::*;

	logic [ROOT_W-1:0]  root_q;
	logic [FFREE_W-1:0] ffree_q;
	logic [FU_W-1:0]    frames_used_q;
	logic [ADDR_W-1:0]  clr_cnt_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               mode_q;
	logic [VPN_W-1:0]   vpn_q;
	logic [PPN_W-1:0]   ppn_q;
	logic               unmap_q;
	logic [FRAME_W-1:0] cur_q;
	logic [LVL_W-1:0]   lvl_q;
	logic               res_mapped_q;
	logic [PPN_W-1:0]   res_ppn_q;
	logic               res_status_q;

	logic [INDEX_BITS-1:0] idx;
	logic [NXT_W-1:0]      nxt_sum;
	logic [FRAME_W-1:0]    nxt_frame;
	logic                  root_bad;
	logic                  alloc_bad;
	logic                  clr_last;
	logic                  zero_last;
	logic                  last_lvl;
	logic [ENT_W-1:0]      rd_data;
	logic                  ent_valid;
	logic [PPN_W-1:0]      ent_num;
	logic                  ent_follow;
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_waddr;
	logic [ENT_W-1:0]      mem_wdata;

	// Table index of the current level, most significant level first.
	always_comb begin
		idx = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (lvl_q == LVL_W'(l)) begin
				idx = vpn_q[INDEX_BITS*(LEVELS-1-l) +: INDEX_BITS];
			end
		end
	end

	assign nxt_sum   = NXT_W'(ffree_q) + NXT_W'(frames_used_q);
	assign nxt_frame = FRAME_W'(nxt_sum);
	assign alloc_bad = nxt_sum >= NXT_W'(NUM_FRAMES);
	assign root_bad  = 32'(root_q) >= 32'(NUM_FRAMES);
	assign clr_last  = clr_cnt_q == ADDR_W'(DEPTH - 1);
	assign zero_last = &clr_cnt_q[INDEX_BITS-1:0];
	assign last_lvl  = lvl_q == LVL_W'(LEVELS - 1);

	assign ent_valid  = rd_data[0];
	assign ent_num    = rd_data[ENT_W-1:1];
	// A pointer past the last frame counts as a missing level.
	assign ent_follow = ent_valid && (ent_num < PPN_W'(NUM_FRAMES));

	always_comb begin
		mem_we = cmd.clr | cmd.zero | cmd.link | cmd.leaf;
		mem_waddr = {cur_q, idx};
		mem_wdata = '0;
		if (cmd.clr) begin
			mem_waddr = clr_cnt_q;
		end else if (cmd.zero) begin
			mem_waddr = {nxt_frame, clr_cnt_q[INDEX_BITS-1:0]};
		end else if (cmd.link) begin
			mem_wdata = {PPN_W'(nxt_sum), 1'b1};
		end else if (cmd.leaf && !unmap_q) begin
			mem_wdata = {ppn_q, 1'b1};
		end
	end

	rptw_ram #(
		.WIDTH (ENT_W),
		.DEPTH (DEPTH)
	) u_frame_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (cmd.rd),
		.raddr ({cur_q, idx}),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
			ffree_q <= FFREE_W'(1);
			frames_used_q <= '0;
			clr_cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_ROOT_FRAME: root_q <= cfg_data[ROOT_W-1:0];
					CFG_FIRST_FREE: ffree_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.link) begin
				frames_used_q <= frames_used_q + FU_W'(1);
			end
			// The same counter sweeps the whole memory after reset and one frame
			// when it is allocated; both sweeps leave it at zero.
			if (cmd.clr) begin
				clr_cnt_q <= clr_last ? '0 : clr_cnt_q + ADDR_W'(1);
			end else if (cmd.zero) begin
				clr_cnt_q <= zero_last ? '0 : clr_cnt_q + ADDR_W'(1);
			end
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q <= req.mode;
			vpn_q <= req.vpn;
			ppn_q <= req.ppn;
			unmap_q <= req.unmap;
			cur_q <= FRAME_W'(root_q);
			lvl_q <= '0;
			res_mapped_q <= 1'b0;
			res_ppn_q <= '0;
			res_status_q <= root_bad && !req.mode && !req.unmap;
		end
		if (cmd.adv) begin
			cur_q <= FRAME_W'(ent_num);
			lvl_q <= lvl_q + LVL_W'(1);
		end
		if (cmd.link) begin
			cur_q <= nxt_frame;
			lvl_q <= lvl_q + LVL_W'(1);
		end
		if (cmd.hit) begin
			res_mapped_q <= 1'b1;
			res_ppn_q <= ent_num;
		end
		if (cmd.abort) begin
			res_status_q <= 1'b1;
		end
		if (cmd.finish) begin
			rsp_q.mapped <= res_mapped_q;
			rsp_q.ppn_out <= res_ppn_q;
			rsp_q.status <= res_status_q;
		end
	end

	assign rsp = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		sts.mode = mode_q;
		sts.unmap = unmap_q;
		sts.last_lvl = last_lvl;
		sts.root_bad = root_bad;
		sts.ent_valid = ent_valid;
		sts.ent_follow = ent_follow;
		sts.alloc_bad = alloc_bad;
		sts.clr_last = clr_last;
		sts.zero_last = zero_last;
		sts.out_busy = rsp_valid_q && !rsp_ready;
	end

endmodule

### rtl/radix_page_table_walker_core.sv
// Five-level radix page table walker over an internal frame memory.
// The req channel takes one item (mode, vpn, ppn, unmap); a query walks the tables
// and an update walks them, allocating zeroed frames for missing levels when it
// maps, then writes or clears the leaf. The rsp channel returns one item (mapped,
// ppn_out, status) per request. The cfg channel writes root_frame (index 0) and
// first_free_frame (index 1); it is always ready. It must be written while idle;
// the block itself does not enforce it. The block works on one item at a time.
// Each level is read in a read state and checked in an evaluate state, as the
// frame memory's read port is registered; an update writes its leaf straight
// from the read state. Each frame allocated adds a zeroing sweep of the new
// frame through the memory's single write port.
// After reset the block clears the whole frame memory, one entry a cycle, with
// req_ready low.
// The result waits in an output register; the block takes the next item while
// it is stalled, and holds its following result until the register frees.
// Depends on rptw_pkg, rptw_ctrl and rptw_datapath.
module radix_page_table_walker_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  rptw_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output rptw_pkg::rsp_t                 rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rptw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rptw_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rptw_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	rptw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rptw_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

### rtl/rptw_checker.sv
// Port-level checker of the page table walker and its bind to the top level.
// Depends on rptw_pkg and radix_page_table_walker_core_assert.svh.
`include "radix_page_table_walker_core_assert.svh"

module rptw_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input rptw_pkg::rsp_t rsp
);
	import rptw_pkg::*;

	// A stalled result keeps its item.
	`RPTW_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// Only a query reports a mapping, only an update reports an abort.
	`RPTW_ASSERT_IMPL(a_mapped_or_status, clk, arst_n, rsp_valid, !(rsp.mapped && rsp.status))

	// A result without a mapping carries no page number.
	`RPTW_ASSERT_IMPL(a_ppn_zero, clk, arst_n, rsp_valid && !rsp.mapped, rsp.ppn_out == '0)

	// The walker works on one item at a time.
	`RPTW_ASSERT_NEXT(a_one_item, clk, arst_n, req_valid && req_ready, !req_ready)

endmodule

bind radix_page_table_walker_core rptw_checker u_rptw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
